// ===== hw/rtl/tpd_pkg.sv =====
// tpd_pkg: shared types, constants and the sine table of the torus patch dicer
`default_nettype none

package tpd_pkg;

    localparam int MAX_GRID_SIDE     = 8;
    localparam int SINCOS_INDEX_BITS = 10;

    localparam int SIDE_IN_W  = 4;
    localparam int SIDE_W     = $clog2(MAX_GRID_SIDE);
    localparam int UV_W       = 17;
    localparam int DIV_STEPS  = UV_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int IDX_W      = SINCOS_INDEX_BITS;
    localparam int QUARTER    = 1 << (IDX_W - 2);
    localparam int ANG_W      = 20;
    localparam int TRIG_W     = 16;
    localparam int P_W        = 27;
    localparam int ACC_W      = 48;
    localparam int COORD_W    = 32;
    localparam int COEF_W     = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 328;

    localparam logic [UV_W-1:0]          UNIT_UV      = UV_W'(65536);
    localparam logic signed [19:0]       TURN_SCALE   = 20'sd166886;
    localparam logic [31:0]              PHASE_HALF   = 32'd1 << (31 - IDX_W);
    localparam logic [IDX_W-1:0]         QUARTER_IDX  = IDX_W'(QUARTER);

    localparam logic [CFG_DATA_W-1:0] RST_MATRIX_X = 64'd256;
    localparam logic [CFG_DATA_W-1:0] RST_MATRIX_Y = 64'd16777216;
    localparam logic [CFG_DATA_W-1:0] RST_MATRIX_Z = 64'd1099511627776;
    localparam logic [23:0]           RST_MAJOR    = 24'd4096;
    localparam logic [23:0]           RST_MINOR    = 24'd1024;
    localparam logic [15:0]           RST_PHI_LO   = 16'd0;
    localparam logic [15:0]           RST_PHI_HI   = 16'd25736;
    localparam logic [15:0]           RST_SWEEP    = 16'd25736;

    localparam longint unsigned SIN_A1 = 64'd1686629713;
    localparam longint unsigned SIN_A3 = 64'd693598668;
    localparam longint unsigned SIN_A5 = 64'd85569306;
    localparam longint unsigned SIN_A7 = 64'd5026995;
    localparam longint unsigned SIN_A9 = 64'd172272;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MATRIX_X = 3'd0,
        REG_MATRIX_Y = 3'd1,
        REG_MATRIX_Z = 3'd2,
        REG_MAJOR    = 3'd3,
        REG_MINOR    = 3'd4,
        REG_PHI_LO   = 3'd5,
        REG_PHI_HI   = 3'd6,
        REG_SWEEP    = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ANG_MUL,
        ST_ANG_RND,
        ST_PHASE,
        ST_TRIG,
        ST_RAD_MUL,
        ST_RAD_RND,
        ST_RING_MUL,
        ST_RING_RND,
        ST_XF_MUL,
        ST_XF_SUM,
        ST_EMIT
    } tpd_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic ang_mul;
        logic ang_rnd;
        logic phase;
        logic trig;
        logic rad_mul;
        logic rad_rnd;
        logic ring_mul;
        logic ring_rnd;
        logic xf_mul;
        logic xf_sum;
        logic emit;
    } tpd_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic last_vertex;
    } tpd_status_t;

    typedef logic [14:0] sine_lut_t [0:QUARTER];

    // quarter-wave sine, Q2.14, from the odd polynomial in Q30
    function automatic sine_lut_t build_sine_lut();
        sine_lut_t lut;
        longint unsigned z, z2, t, s;
        for (int i = 0; i <= QUARTER; i++) begin
            z  = longint'(i) << (32 - IDX_W);
            z2 = (z * z) >> 30;
            t  = SIN_A7 - ((SIN_A9 * z2) >> 30);
            t  = SIN_A5 - ((t * z2) >> 30);
            t  = SIN_A3 - ((t * z2) >> 30);
            t  = SIN_A1 - ((t * z2) >> 30);
            s  = (((t * z) >> 30) + 64'd32768) >> 16;
            if (s > 64'd16384) s = 64'd16384;
            lut[i] = s[14:0];
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine_lut();

    function automatic logic signed [TRIG_W-1:0] sine_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W-3:0] r;
        logic [IDX_W-2:0] a;
        logic [TRIG_W-1:0] s;
        r = idx[IDX_W-3:0];
        a = idx[IDX_W-2] ? ((IDX_W-1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
        s = TRIG_W'(SINE_LUT[a]);
        return idx[IDX_W-1] ? -$signed(s) : $signed(s);
    endfunction

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic [COORD_W-1:0] r;
        if (x[ACC_W-1:COORD_W-1] == '0 || x[ACC_W-1:COORD_W-1] == '1) begin
            r = x[COORD_W-1:0];
        end else if (x[ACC_W-1]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7fff_ffff;
        end
        return $signed(r);
    endfunction

    function automatic logic [UV_W-1:0] clamp_uv(input logic [UV_W-1:0] x);
        return (x > UNIT_UV) ? UNIT_UV : x;
    endfunction

    // returns side - 1, side saturated into 2..MAX_GRID_SIDE
    function automatic logic [SIDE_W-1:0] side_last(input logic [SIDE_IN_W-1:0] x);
        logic [SIDE_IN_W-1:0] s;
        if (x < SIDE_IN_W'(2)) begin
            s = SIDE_IN_W'(2);
        end else if (x > SIDE_IN_W'(MAX_GRID_SIDE)) begin
            s = SIDE_IN_W'(MAX_GRID_SIDE);
        end else begin
            s = x;
        end
        return SIDE_W'(s - SIDE_IN_W'(1));
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tpd_ctrl.sv =====
// tpd_ctrl: sequencer that walks setup, division and the per-vertex steps
`default_nettype none

module tpd_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire tpd_pkg::tpd_status_t status,
    output tpd_pkg::tpd_cmd_t        cmd
);
    import tpd_pkg::*;

    tpd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_DIVIDE;
            ST_DIVIDE:   if (status.div_done) state_next = ST_ANG_MUL;
            ST_ANG_MUL:  state_next = ST_ANG_RND;
            ST_ANG_RND:  state_next = ST_PHASE;
            ST_PHASE:    state_next = ST_TRIG;
            ST_TRIG:     state_next = ST_RAD_MUL;
            ST_RAD_MUL:  state_next = ST_RAD_RND;
            ST_RAD_RND:  state_next = ST_RING_MUL;
            ST_RING_MUL: state_next = ST_RING_RND;
            ST_RING_RND: state_next = ST_XF_MUL;
            ST_XF_MUL:   state_next = ST_XF_SUM;
            ST_XF_SUM:   state_next = ST_EMIT;
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = status.last_vertex ? ST_IDLE : ST_ANG_MUL;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DIVIDE:   cmd.div_step = 1'b1;
            ST_ANG_MUL:  cmd.ang_mul  = 1'b1;
            ST_ANG_RND:  cmd.ang_rnd  = 1'b1;
            ST_PHASE:    cmd.phase    = 1'b1;
            ST_TRIG:     cmd.trig     = 1'b1;
            ST_RAD_MUL:  cmd.rad_mul  = 1'b1;
            ST_RAD_RND:  cmd.rad_rnd  = 1'b1;
            ST_RING_MUL: cmd.ring_mul = 1'b1;
            ST_RING_RND: cmd.ring_rnd = 1'b1;
            ST_XF_MUL:   cmd.xf_mul   = 1'b1;
            ST_XF_SUM:   cmd.xf_sum   = 1'b1;
            ST_EMIT:     cmd.emit     = status.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tpd_datapath.sv =====
// tpd_datapath: config registers, step divider, torus evaluation, transform and box
`default_nettype none

module tpd_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tpd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [tpd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic [tpd_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire tpd_pkg::tpd_cmd_t                 cmd,
    output tpd_pkg::tpd_status_t                   status,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tpd_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                   m_tlast
);
    import tpd_pkg::*;

    // configuration
    logic [CFG_DATA_W-1:0] matrix_reg [3];
    logic [23:0]           major_reg, minor_reg;
    logic [15:0]           phi_lo_reg, phi_hi_reg, sweep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_reg[0] <= RST_MATRIX_X;
            matrix_reg[1] <= RST_MATRIX_Y;
            matrix_reg[2] <= RST_MATRIX_Z;
            major_reg     <= RST_MAJOR;
            minor_reg     <= RST_MINOR;
            phi_lo_reg    <= RST_PHI_LO;
            phi_hi_reg    <= RST_PHI_HI;
            sweep_reg     <= RST_SWEEP;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_MATRIX_X: matrix_reg[0] <= cfg_wdata;
                REG_MATRIX_Y: matrix_reg[1] <= cfg_wdata;
                REG_MATRIX_Z: matrix_reg[2] <= cfg_wdata;
                REG_MAJOR:    major_reg     <= cfg_wdata[23:0];
                REG_MINOR:    minor_reg     <= cfg_wdata[23:0];
                REG_PHI_LO:   phi_lo_reg    <= cfg_wdata[15:0];
                REG_PHI_HI:   phi_hi_reg    <= cfg_wdata[15:0];
                REG_SWEEP:    sweep_reg     <= cfg_wdata[15:0];
            endcase
        end
    end

    // request capture
    logic [UV_W-1:0]   in_u0, in_u1, in_v0, in_v1, u1_raw, v1_raw;
    logic [SIDE_W-1:0] in_cl, in_rl;

    always_comb begin
        in_u0  = clamp_uv(s_tdata[16:0]);
        u1_raw = clamp_uv(s_tdata[33:17]);
        in_v0  = clamp_uv(s_tdata[50:34]);
        v1_raw = clamp_uv(s_tdata[67:51]);
        in_u1  = (u1_raw < in_u0) ? in_u0 : u1_raw;
        in_v1  = (v1_raw < in_v0) ? in_v0 : v1_raw;
        in_cl  = side_last(s_tdata[71:68]);
        in_rl  = side_last(s_tdata[75:72]);
    end

    logic [UV_W-1:0]      u0_reg, u1_reg, v1_reg, u_cur_reg, v_cur_reg;
    logic [UV_W-1:0]      u_step_reg, v_step_reg;
    logic [SIDE_W-1:0]    col_last_reg, row_last_reg, col_reg, row_reg;
    logic [SIDE_W-1:0]    rem_u_reg, rem_v_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // restoring divide, one quotient bit per cycle for both sides
    logic [SIDE_W:0]   rsh_u, rsh_v;
    logic              q_u, q_v;
    logic [SIDE_W-1:0] rem_u_next, rem_v_next;

    always_comb begin
        rsh_u = {rem_u_reg, u_step_reg[UV_W-1]};
        rsh_v = {rem_v_reg, v_step_reg[UV_W-1]};
        q_u   = rsh_u >= {1'b0, col_last_reg};
        q_v   = rsh_v >= {1'b0, row_last_reg};
        rem_u_next = q_u ? SIDE_W'(rsh_u - {1'b0, col_last_reg}) : rsh_u[SIDE_W-1:0];
        rem_v_next = q_v ? SIDE_W'(rsh_v - {1'b0, row_last_reg}) : rsh_v[SIDE_W-1:0];
    end

    logic [UV_W:0]   u_sum, v_sum;
    logic [UV_W-1:0] u_adv, v_adv;
    logic            last_vertex;

    always_comb begin
        u_sum = {1'b0, u_cur_reg} + {1'b0, u_step_reg};
        v_sum = {1'b0, v_cur_reg} + {1'b0, v_step_reg};
        u_adv = (u_sum > {1'b0, u1_reg}) ? u1_reg : u_sum[UV_W-1:0];
        v_adv = (v_sum > {1'b0, v1_reg}) ? v1_reg : v_sum[UV_W-1:0];
        last_vertex = (col_reg == col_last_reg) && (row_reg == row_last_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            u0_reg       <= in_u0;
            u1_reg       <= in_u1;
            v1_reg       <= in_v1;
            u_cur_reg    <= in_u0;
            v_cur_reg    <= in_v0;
            col_last_reg <= in_cl;
            row_last_reg <= in_rl;
            col_reg      <= '0;
            row_reg      <= '0;
            rem_u_reg    <= '0;
            rem_v_reg    <= '0;
            div_cnt_reg  <= '0;
            // dividend of the rounded-up step
            u_step_reg   <= (in_u1 - in_u0) + UV_W'(in_cl) - UV_W'(1);
            v_step_reg   <= (in_v1 - in_v0) + UV_W'(in_rl) - UV_W'(1);
        end else if (cmd.div_step) begin
            rem_u_reg   <= rem_u_next;
            rem_v_reg   <= rem_v_next;
            u_step_reg  <= {u_step_reg[UV_W-2:0], q_u};
            v_step_reg  <= {v_step_reg[UV_W-2:0], q_v};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end else if (cmd.emit) begin
            if (col_reg == col_last_reg) begin
                col_reg   <= '0;
                row_reg   <= row_reg + SIDE_W'(1);
                u_cur_reg <= u0_reg;
                v_cur_reg <= v_adv;
            end else begin
                col_reg   <= col_reg + SIDE_W'(1);
                u_cur_reg <= u_adv;
            end
        end
    end

    // angles
    logic signed [33:0]     thp_reg;
    logic signed [34:0]     php_reg;
    logic signed [ANG_W-1:0] theta_reg, phi_reg;
    logic [31:0]            ph_t_reg, ph_p_reg;
    logic signed [16:0]     dphi;
    logic signed [39:0]     turn_t, turn_p;

    always_comb begin
        dphi   = $signed({phi_hi_reg[15], phi_hi_reg}) - $signed({phi_lo_reg[15], phi_lo_reg});
        turn_t = theta_reg * TURN_SCALE;
        turn_p = phi_reg * TURN_SCALE;
    end

    // trig and torus point
    logic signed [TRIG_W-1:0] sin_t_reg, cos_t_reg, sin_p_reg, cos_p_reg;
    logic signed [39:0]       rp_reg, zp_reg;
    logic signed [P_W-1:0]    ring_reg, px_reg, py_reg, pz_reg;
    logic signed [42:0]       pxp_reg, pyp_reg;
    logic [IDX_W-1:0]         idx_t, idx_p;

    assign idx_t = ph_t_reg[31 -: IDX_W];
    assign idx_p = ph_p_reg[31 -: IDX_W];

    // transform
    logic signed [42:0]        xprod_reg [3][3];
    logic signed [COORD_W-1:0] t_reg [3];
    logic signed [P_W-1:0]     p_vec [3];
    logic signed [ACC_W-1:0]   acc [3];
    logic signed [ACC_W-1:0]   acc_rnd [3];

    always_comb begin
        p_vec[0] = px_reg;
        p_vec[1] = py_reg;
        p_vec[2] = pz_reg;
        for (int r = 0; r < 3; r++) begin
            acc[r] = ACC_W'(xprod_reg[r][0]) + ACC_W'(xprod_reg[r][1])
                   + ACC_W'(xprod_reg[r][2])
                   + (ACC_W'($signed(matrix_reg[r][63:48])) <<< 12);
            acc_rnd[r] = (acc[r] + ACC_W'(128)) >>> 8;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ang_mul) begin
            thp_reg <= $signed({1'b0, u_cur_reg}) * $signed(sweep_reg);
            php_reg <= dphi * $signed({1'b0, v_cur_reg});
        end
        if (cmd.ang_rnd) begin
            theta_reg <= ANG_W'((thp_reg + 34'sd32768) >>> 16);
            phi_reg   <= ANG_W'((php_reg + 35'sd32768) >>> 16) + ANG_W'($signed(phi_lo_reg));
        end
        if (cmd.phase) begin
            ph_t_reg <= turn_t[31:0] + PHASE_HALF;
            ph_p_reg <= turn_p[31:0] + PHASE_HALF;
        end
        if (cmd.trig) begin
            sin_t_reg <= sine_of(idx_t);
            cos_t_reg <= sine_of(idx_t + QUARTER_IDX);
            sin_p_reg <= sine_of(idx_p);
            cos_p_reg <= sine_of(idx_p + QUARTER_IDX);
        end
        if (cmd.rad_mul) begin
            rp_reg <= $signed(minor_reg) * cos_p_reg;
            zp_reg <= $signed(minor_reg) * sin_p_reg;
        end
        if (cmd.rad_rnd) begin
            ring_reg <= P_W'((rp_reg + 40'sd8192) >>> 14) + P_W'($signed(major_reg));
            pz_reg   <= P_W'((zp_reg + 40'sd8192) >>> 14);
        end
        if (cmd.ring_mul) begin
            pxp_reg <= ring_reg * cos_t_reg;
            pyp_reg <= ring_reg * sin_t_reg;
        end
        if (cmd.ring_rnd) begin
            px_reg <= P_W'((pxp_reg + 43'sd8192) >>> 14);
            py_reg <= P_W'((pyp_reg + 43'sd8192) >>> 14);
        end
        if (cmd.xf_mul) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    xprod_reg[r][k] <= $signed(matrix_reg[r][16*k +: COEF_W]) * p_vec[k];
                end
            end
        end
        if (cmd.xf_sum) begin
            for (int r = 0; r < 3; r++) begin
                t_reg[r] <= sat32(acc_rnd[r]);
            end
        end
    end

    // bounding box and output register
    logic signed [COORD_W-1:0] box_min_reg [3], box_max_reg [3];
    logic signed [COORD_W-1:0] box_min_next [3], box_max_next [3];
    logic [COORD_W-1:0]        box_min_out [3], box_max_out [3];
    logic                      m_tvalid_reg, m_tlast_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            box_min_next[k] = (t_reg[k] < box_min_reg[k]) ? t_reg[k] : box_min_reg[k];
            box_max_next[k] = (t_reg[k] > box_max_reg[k]) ? t_reg[k] : box_max_reg[k];
            box_min_out[k]  = last_vertex ? box_min_next[k] : '0;
            box_max_out[k]  = last_vertex ? box_max_next[k] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                box_min_reg[k] <= 32'sh7fff_ffff;
                box_max_reg[k] <= 32'sh8000_0000;
            end
        end else if (cmd.emit) begin
            for (int k = 0; k < 3; k++) begin
                box_min_reg[k] <= box_min_next[k];
                box_max_reg[k] <= box_max_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tlast_reg <= last_vertex;
            m_tdata_reg <= {6'd0,
                            box_max_out[2], box_max_out[1], box_max_out[0],
                            box_min_out[2], box_min_out[1], box_min_out[0],
                            v_cur_reg, u_cur_reg,
                            t_reg[2], t_reg[1], t_reg[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

    assign status.div_done    = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status.out_free    = !m_tvalid_reg || m_tready;
    assign status.last_vertex = last_vertex;

endmodule

`default_nettype wire

// ===== hw/rtl/torus_patch_dicer.sv =====
// torus_patch_dicer: dices a uv sub-patch of a partial torus into transformed grid points
//
// s_ channel: one beat per request (uv range and grid size). m_ channel: one
// beat per grid vertex, row by row, tlast on the final vertex, which also
// carries the bounding box of the grid (box fields are zero on other beats).
// cfg_wr_en/cfg_addr/cfg_wdata write the matrix rows, radii and angles; write
// only while no request is in flight.
// Sequence: after a request is taken, the step division runs (one quotient bit
// per cycle), and then each vertex passes through the shared evaluation
// datapath (angle, phase, table lookup, radius, ring, transform multiply, sum,
// emit); the next request is taken once the last vertex has been loaded into
// the output register. When m_tready is low the finished vertex waits in the
// output register and the sequencer holds before loading the next one.
// Reset (aresetn low, synchronous) returns the sequencer to idle, drops
// m_tvalid and restores the default torus and identity transform.
`default_nettype none

module torus_patch_dicer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tpd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [tpd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // u_start, u_end, v_start, v_end, grid_width, grid_height
    input  wire logic [tpd_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // point_x, point_y, point_z, s_coord, t_coord,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    output logic [tpd_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                   m_tlast
);
    import tpd_pkg::*;

    tpd_cmd_t    cmd;
    tpd_status_t status;

    tpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tpd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // a request keeps the block busy after it is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // a stalled vertex beat stays put until it is taken
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("vertex beat changed while stalled");

    // a vertex beat must not rise early in the step division that follows a taken request
    a_no_out_in_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 !$rose(m_tvalid))
        else $error("vertex beat during setup");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench for torus_patch_dicer: self-checking stream test with a bit-exact grid predictor
`timescale 1ns / 1ps

module testbench;
    import tpd_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int IDX_N = SINCOS_INDEX_BITS;

    typedef struct {
        logic [16:0] u_lo, u_hi, v_lo, v_hi;
        logic [3:0]  cols, rows;
    } patch_req_t;

    typedef struct {
        int          px, py, pz;
        logic [16:0] s, t;
        logic        last;
        int          bx [6];
    } grid_point_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tlast;

    torus_patch_dicer u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // shadow of the configuration
    logic [63:0] row_x, row_y, row_z;
    logic [23:0] major_r, minor_r;
    logic [15:0] phi_lo, phi_hi, sweep;

    patch_req_t  pending_reqs [$];
    grid_point_t expected_points [$];
    patch_req_t  cur_req;
    int send_idle = 0, recv_stall = 0;
    bit recv_hold = 1'b0;
    int errors = 0, reqs_taken = 0, points_seen = 0, grids_done = 0, cycles = 0;

    function automatic longint round_sh(longint x, int n);
        return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint quarter_wave(int unsigned r);
        longint unsigned z, z2, c, s;
        z  = longint'(r) << (32 - IDX_N);
        z2 = (z * z) >> 30;
        c  = SIN_A7 - ((SIN_A9 * z2) >> 30);
        c  = SIN_A5 - ((c * z2) >> 30);
        c  = SIN_A3 - ((c * z2) >> 30);
        c  = SIN_A1 - ((c * z2) >> 30);
        s  = (((c * z) >> 30) + 64'd32768) >> 16;
        if (s > 64'd16384) s = 64'd16384;
        return longint'(s);
    endfunction

    function automatic longint sine_q14(int unsigned idx);
        int unsigned qtr, quad, r;
        longint s;
        qtr  = 1 << (IDX_N - 2);
        idx  = idx & ((1 << IDX_N) - 1);
        quad = idx >> (IDX_N - 2);
        r    = idx & (qtr - 1);
        s    = quad[0] ? quarter_wave(qtr - r) : quarter_wave(r);
        return quad[1] ? -s : s;
    endfunction

    function automatic int unsigned turn_index(longint ang);
        longint unsigned ph;
        ph = longint'(ang * 166886) & 64'hFFFF_FFFF;
        ph = (ph + (64'd1 << (31 - IDX_N))) & 64'hFFFF_FFFF;
        return int'(ph >> (32 - IDX_N));
    endfunction

    function automatic int apply_row(logic [63:0] m, longint p [3]);
        longint acc;
        acc = 0;
        for (int k = 0; k < 3; k++) acc += longint'($signed(m[16*k +: 16])) * p[k];
        acc += longint'($signed(m[63:48])) * 4096;
        acc = round_sh(acc, 8);
        if (acc > 64'sd2147483647) return 32'sh7fff_ffff;
        if (acc < -64'sd2147483648) return 32'sh8000_0000;
        return int'(acc);
    endfunction

    function automatic int unsigned uv_clip(logic [16:0] x);
        return (x > 17'd65536) ? 65536 : int'(x);
    endfunction

    function automatic int unsigned side_clip(logic [3:0] x);
        if (x < 4'd2) return 2;
        if (x > 4'(MAX_GRID_SIDE)) return MAX_GRID_SIDE;
        return int'(x);
    endfunction

    task automatic dice_patch(patch_req_t rq);
        int unsigned u0, u1, v0, v1, w, h, du, dv, u, v, qt, ti, pi;
        longint major, minor, p0, p1, sw, theta, phi, ring;
        longint p [3];
        int xf [3];
        int box [6];
        grid_point_t gp;
        u0 = uv_clip(rq.u_lo); u1 = uv_clip(rq.u_hi);
        v0 = uv_clip(rq.v_lo); v1 = uv_clip(rq.v_hi);
        w = side_clip(rq.cols); h = side_clip(rq.rows);
        if (u1 < u0) u1 = u0;
        if (v1 < v0) v1 = v0;
        du = (u1 - u0 + w - 2) / (w - 1);
        dv = (v1 - v0 + h - 2) / (h - 1);
        major = $signed(major_r); minor = $signed(minor_r);
        p0 = $signed(phi_lo); p1 = $signed(phi_hi); sw = $signed(sweep);
        qt = 1 << (IDX_N - 2);
        for (int k = 0; k < 3; k++) begin
            box[k] = 32'sh7fff_ffff;
            box[k+3] = 32'sh8000_0000;
        end
        v = v0;
        for (int rr = 0; rr < h; rr++) begin
            u = u0;
            for (int cc = 0; cc < w; cc++) begin
                theta = round_sh(longint'(u) * sw, 16);
                phi   = p0 + round_sh((p1 - p0) * longint'(v), 16);
                ti = turn_index(theta);
                pi = turn_index(phi);
                ring = major + round_sh(minor * sine_q14(pi + qt), 14);
                p[0] = round_sh(ring * sine_q14(ti + qt), 14);
                p[1] = round_sh(ring * sine_q14(ti), 14);
                p[2] = round_sh(minor * sine_q14(pi), 14);
                xf[0] = apply_row(row_x, p);
                xf[1] = apply_row(row_y, p);
                xf[2] = apply_row(row_z, p);
                for (int k = 0; k < 3; k++) begin
                    if (xf[k] < box[k]) box[k] = xf[k];
                    if (xf[k] > box[k+3]) box[k+3] = xf[k];
                end
                gp.px = xf[0]; gp.py = xf[1]; gp.pz = xf[2];
                gp.s = 17'(u); gp.t = 17'(v);
                gp.last = (rr == h - 1) && (cc == w - 1);
                for (int k = 0; k < 6; k++) gp.bx[k] = gp.last ? box[k] : 0;
                expected_points.insert(expected_points.size(), gp);
                u = (u + du > u1) ? u1 : u + du;
            end
            v = (v + dv > v1) ? v1 : v + dv;
        end
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                dice_patch(cur_req);
                reqs_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cur_req = pending_reqs.pop_front();
                    s_tdata <= {4'b0, cur_req.rows, cur_req.cols, cur_req.v_hi, cur_req.v_lo,
                                cur_req.u_hi, cur_req.u_lo};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // receiver and checker
    always @(posedge aclk) begin
        grid_point_t gp;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                points_seen++;
                if (expected_points.size() == 0) begin
                    $error("unexpected result beat");
                    errors++;
                end else begin
                    gp = expected_points.pop_front();
                    check_field("point_x", gp.px, $signed(m_tdata[31:0]));
                    check_field("point_y", gp.py, $signed(m_tdata[63:32]));
                    check_field("point_z", gp.pz, $signed(m_tdata[95:64]));
                    check_field("s_coord", gp.s, m_tdata[112:96]);
                    check_field("t_coord", gp.t, m_tdata[129:113]);
                    check_field("last_point", gp.last, m_tlast);
                    check_field("box_min_x", gp.bx[0], $signed(m_tdata[161:130]));
                    check_field("box_min_y", gp.bx[1], $signed(m_tdata[193:162]));
                    check_field("box_min_z", gp.bx[2], $signed(m_tdata[225:194]));
                    check_field("box_max_x", gp.bx[3], $signed(m_tdata[257:226]));
                    check_field("box_max_y", gp.bx[4], $signed(m_tdata[289:258]));
                    check_field("box_max_z", gp.bx[5], $signed(m_tdata[321:290]));
                    if (gp.last) grids_done++;
                end
            end
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_MATRIX_X: row_x = val;
            REG_MATRIX_Y: row_y = val;
            REG_MATRIX_Z: row_z = val;
            REG_MAJOR:    major_r = val[23:0];
            REG_MINOR:    minor_r = val[23:0];
            REG_PHI_LO:   phi_lo = val[15:0];
            REG_PHI_HI:   phi_hi = val[15:0];
            default:      sweep = val[15:0];
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic patch_req_t make_req(int u0, int u1, int v0, int v1, int w, int h);
        patch_req_t rq;
        rq.u_lo = 17'(u0); rq.u_hi = 17'(u1);
        rq.v_lo = 17'(v0); rq.v_hi = 17'(v1);
        rq.cols = 4'(w); rq.rows = 4'(h);
        return rq;
    endfunction

    task automatic enqueue_req(patch_req_t rq);
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    function automatic patch_req_t random_req();
        int a, b, c, d;
        if ($urandom_range(99) < 20) begin
            // noise: any bit pattern, ranges reversed or past one
            return make_req($urandom_range(131071), $urandom_range(131071),
                            $urandom_range(131071), $urandom_range(131071),
                            $urandom_range(15), $urandom_range(15));
        end
        a = $urandom_range(65536); b = $urandom_range(65536, a);
        c = $urandom_range(65536); d = $urandom_range(65536, c);
        if ($urandom_range(9) == 0)
            return make_req(a, b, c, d, $urandom_range(8, 2), $urandom_range(8, 2));
        return make_req(a, b, c, d, $urandom_range(4, 2), $urandom_range(4, 2));
    endfunction

    task automatic drain(int settle);
        while (pending_reqs.size() > 0 || s_tvalid || expected_points.size() > 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic random_config();
        write_reg(REG_MATRIX_X, {$urandom, $urandom} & 64'h03ff_81ff_01ff_83ff);
        write_reg(REG_MATRIX_Y, {$urandom, $urandom});
        write_reg(REG_MATRIX_Z, {$urandom, $urandom} & 64'hffff_03ff_83ff_81ff);
        write_reg(REG_MAJOR, 64'($urandom));
        write_reg(REG_MINOR, 64'($urandom));
        write_reg(REG_PHI_LO, 64'($urandom));
        write_reg(REG_PHI_HI, 64'($urandom));
        write_reg(REG_SWEEP, 64'($urandom));
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle = idle;
        recv_stall = stall;
        repeat (n) enqueue_req(random_req());
        drain(40);
    endtask

    initial begin
        row_x = RST_MATRIX_X; row_y = RST_MATRIX_Y; row_z = RST_MATRIX_Z;
        major_r = RST_MAJOR; minor_r = RST_MINOR;
        phi_lo = RST_PHI_LO; phi_hi = RST_PHI_HI; sweep = RST_SWEEP;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: full range, points, reversed, out of range values, odd sizes
        enqueue_req(make_req(0, 65536, 0, 65536, 8, 8));
        enqueue_req(make_req(0, 0, 0, 0, 2, 2));
        enqueue_req(make_req(65536, 65536, 65536, 65536, 2, 2));
        enqueue_req(make_req(131071, 131071, 131071, 131071, 3, 2));
        enqueue_req(make_req(70000, 1000, 90000, 5, 2, 3));
        enqueue_req(make_req(40000, 100, 30000, 200, 4, 3));
        enqueue_req(make_req(0, 65536, 0, 65536, 0, 1));
        enqueue_req(make_req(0, 65536, 0, 65536, 15, 9));
        enqueue_req(make_req(1, 65535, 32768, 65536, 7, 5));
        enqueue_req(make_req(0, 5, 0, 3, 8, 8));
        enqueue_req(make_req(21845, 43690, 43690, 65535, 3, 3));
        enqueue_req(make_req(65535, 65536, 0, 1, 2, 8));
        drain(40);

        // extremes of every register but matrix row z
        write_reg(REG_MATRIX_X, 64'h7fff_7fff_7fff_7fff);
        write_reg(REG_MATRIX_Y, 64'h8000_8000_8000_8000);
        write_reg(REG_MATRIX_Z, 64'h0000_0100_ffff_0001);
        write_reg(REG_MAJOR, 64'h7f_ffff);
        write_reg(REG_MINOR, 64'h80_0000);
        write_reg(REG_PHI_LO, 64'h8000);
        write_reg(REG_PHI_HI, 64'h7fff);
        write_reg(REG_SWEEP, 64'h8000);
        enqueue_req(make_req(0, 65536, 0, 65536, 8, 8));
        enqueue_req(make_req(131071, 0, 0, 131071, 5, 4));
        enqueue_req(make_req(0, 65536, 0, 65536, 3, 3));
        drain(40);

        random_config();
        random_phase(60, 0, 0);

        random_config();
        // long receiver hold while the sender keeps offering
        fork
            begin
                recv_hold = 1'b1;
                repeat (800) @(posedge aclk);
                recv_hold = 1'b0;
            end
            random_phase(60, 0, 0);
        join

        random_config();
        random_phase(60, 46, 0);

        write_reg(REG_MAJOR, 64'h00_0000);
        write_reg(REG_MINOR, 64'h7f_ffff);
        write_reg(REG_SWEEP, 64'h7fff);
        write_reg(REG_PHI_LO, 64'h0000);
        random_phase(60, 0, 46);

        random_config();
        random_phase(60, 18, 18);

        drain(100);
        $display("run covered %0d requests and %0d points over %0d grids",
                 reqs_taken, points_seen, grids_done);
        $display("with register extremes, clipped ranges and sizes, stalls and a long hold");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_ctrl.sv
hw/rtl/tpd_datapath.sv
hw/rtl/torus_patch_dicer.sv
tb/sv/testbench.sv
